@@ hw/rtl/aes128_pkg.sv @@
// Package for the AES-128 pipeline: types, S-box tables and round helpers.
package aes128_pkg;

	localparam int NumRounds = 10;
	localparam int BlockW    = 128;
	localparam int HalfW     = 64;
	localparam int CfgIdxW   = 1;

	typedef enum logic [0:0] {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} aes_op_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} aes_reg_t;

	typedef logic [7:0] byte_t;
	typedef logic [BlockW-1:0] block_t;

	typedef struct packed {
		logic   valid;
		aes_op_t op;
	} stage_ctl_t;

	localparam byte_t SBOX_FWD [256] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	localparam byte_t SBOX_INV [256] = '{
		8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
		8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
		8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
		8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
		8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
		8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
		8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
		8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
		8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
		8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
		8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
		8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
		8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
		8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
		8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
	};

	localparam byte_t GF_REDUCE = 8'h1B;

	// Byte n of a block sits at bits [127-8n -: 8].
	function automatic byte_t get_byte(block_t b, int n);
		return b[BlockW-1-8*n -: 8];
	endfunction

	function automatic byte_t xtime(byte_t v);
		return {v[6:0], 1'b0} ^ (v[7] ? GF_REDUCE : 8'h00);
	endfunction

	// Forward round key step; rc is the round constant for the new key.
	function automatic block_t next_round_key(block_t prev, byte_t rc);
		byte_t  w [4];
		byte_t  cur [16];
		block_t res;
		w[0] = SBOX_FWD[get_byte(prev, 13)] ^ rc;
		w[1] = SBOX_FWD[get_byte(prev, 14)];
		w[2] = SBOX_FWD[get_byte(prev, 15)];
		w[3] = SBOX_FWD[get_byte(prev, 12)];
		for (int n = 0; n < 4; n++) cur[n] = get_byte(prev, n) ^ w[n];
		for (int n = 4; n < 16; n++) cur[n] = cur[n-4] ^ get_byte(prev, n);
		for (int n = 0; n < 16; n++) res[BlockW-1-8*n -: 8] = cur[n];
		return res;
	endfunction

	function automatic block_t sub_shift(block_t s, logic inv);
		block_t t;
		int     src;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
				t[BlockW-1-8*(c*4+r) -: 8] = inv ? SBOX_INV[get_byte(s, src*4+r)]
					: SBOX_FWD[get_byte(s, src*4+r)];
			end
		return t;
	endfunction

	function automatic block_t mix_fwd(block_t s);
		block_t t;
		byte_t  a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, c*4);
			a1 = get_byte(s, c*4+1);
			a2 = get_byte(s, c*4+2);
			a3 = get_byte(s, c*4+3);
			t[BlockW-1-8*(c*4)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			t[BlockW-1-8*(c*4+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			t[BlockW-1-8*(c*4+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			t[BlockW-1-8*(c*4+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end
		return t;
	endfunction

	// Inverse mix columns as a preconditioning step followed by the forward mix.
	function automatic block_t mix_inv(block_t s);
		block_t u;
		byte_t  a0, a1, a2, a3, p, q;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, c*4);
			a1 = get_byte(s, c*4+1);
			a2 = get_byte(s, c*4+2);
			a3 = get_byte(s, c*4+3);
			p  = xtime(xtime(a0 ^ a2));
			q  = xtime(xtime(a1 ^ a3));
			u[BlockW-1-8*(c*4)   -: 8] = a0 ^ p;
			u[BlockW-1-8*(c*4+1) -: 8] = a1 ^ q;
			u[BlockW-1-8*(c*4+2) -: 8] = a2 ^ p;
			u[BlockW-1-8*(c*4+3) -: 8] = a3 ^ q;
		end
		return mix_fwd(u);
	endfunction

endpackage

@@ hw/rtl/aes128_if.sv @@
// Valid/ready channel interfaces for blocks, results and configuration writes.
interface aes128_in_if;
	import aes128_pkg::*;
	logic             valid;
	logic             ready;
	logic             opcode;
	logic [HalfW-1:0] block_high;
	logic [HalfW-1:0] block_low;
	modport source (output valid, opcode, block_high, block_low, input ready);
	modport sink (input valid, opcode, block_high, block_low, output ready);
endinterface

interface aes128_out_if;
	import aes128_pkg::*;
	logic             valid;
	logic             ready;
	logic [HalfW-1:0] out_high;
	logic [HalfW-1:0] out_low;
	modport source (output valid, out_high, out_low, input ready);
	modport sink (input valid, out_high, out_low, output ready);
endinterface

interface aes128_cfg_if;
	import aes128_pkg::*;
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [HalfW-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/aes128_round_cell.sv @@
// One round cell: computes a round of the block and the next round key, then registers both.
module aes128_round_cell import aes128_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic       last,
	input  byte_t      rc,
	input  stage_ctl_t ctl_in,
	input  block_t     state_in,
	input  block_t     key_in,
	output stage_ctl_t ctl_s1,
	output block_t     state_s1,
	output block_t     key_s1
);

	block_t key_next;
	block_t state_next;
	block_t ss;

	// Decryption walks round keys backward: the previous key is derived by
	// unwinding the schedule, so each cell computes one step in either direction.
	function automatic block_t prev_round_key(block_t cur, byte_t rcv);
		byte_t  p [16];
		byte_t  w [4];
		block_t res;
		for (int n = 15; n >= 4; n--) p[n] = get_byte(cur, n) ^ get_byte(cur, n-4);
		w[0] = SBOX_FWD[p[13]] ^ rcv;
		w[1] = SBOX_FWD[p[14]];
		w[2] = SBOX_FWD[p[15]];
		w[3] = SBOX_FWD[p[12]];
		for (int n = 0; n < 4; n++) p[n] = get_byte(cur, n) ^ w[n];
		for (int n = 0; n < 16; n++) res[BlockW-1-8*n -: 8] = p[n];
		return res;
	endfunction

	always_comb begin
		ss = sub_shift(state_in, ctl_in.op == OP_DECRYPT);
		if (ctl_in.op == OP_ENCRYPT) begin
			key_next   = next_round_key(key_in, rc);
			state_next = (last ? ss : mix_fwd(ss)) ^ key_next;
		end else begin
			key_next   = prev_round_key(key_in, rc);
			state_next = last ? (ss ^ key_next) : mix_inv(ss ^ key_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (advance) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			state_s1 <= state_next;
			key_s1   <= key_next;
		end
	end

endmodule

@@ hw/rtl/aes128_block_cipher.sv @@
// An input block passes the entry register, ten round cells and the output register.
// Throughput: one block per cycle unless stalled; each cell holds a block and its round key.
// The whole chain advances together and holds while the output register is full and stalled.
// A schedule unit builds the last round key for decrypt one round per cycle; input
// holds after reset and after each key write while it runs.
// Reset clears all valid bits and sets both key registers to zero.
module aes128_block_cipher import aes128_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	aes128_in_if.sink    in_ch,
	aes128_out_if.source out_ch,
	aes128_cfg_if.sink   cfg
);

	typedef logic [$clog2(NumRounds+1)-1:0] kcnt_t;

	logic [HalfW-1:0] key_high_q;
	logic [HalfW-1:0] key_low_q;
	byte_t            rcon [NumRounds+1];
	stage_ctl_t       ctl [NumRounds+1];
	block_t           st [NumRounds+1];
	block_t           rk [NumRounds+1];
	logic             advance;
	block_t           in_blk;
	block_t           key0;
	logic             out_valid_q;
	block_t           out_q;
	block_t           kgen_key_q;
	byte_t            kgen_rc_q;
	kcnt_t            kgen_cnt_q;
	logic             key_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_KEY_HIGH: key_high_q <= cfg.data;
				REG_KEY_LOW:  key_low_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// Round constants; rcon[r] builds round key r.
	assign key0 = {key_high_q, key_low_q};
	always_comb begin
		rcon[0] = 8'h00;
		rcon[1] = 8'h01;
		for (int r = 2; r <= NumRounds; r++) rcon[r] = xtime(rcon[r-1]);
	end

	// Last round key: restart from the new key on a write, then advance one round per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kgen_key_q <= '0;
			kgen_rc_q  <= 8'h01;
			kgen_cnt_q <= kcnt_t'(NumRounds);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_KEY_HIGH: kgen_key_q <= {cfg.data, key_low_q};
				REG_KEY_LOW:  kgen_key_q <= {key_high_q, cfg.data};
				default:      kgen_key_q <= key0;
			endcase
			kgen_rc_q  <= 8'h01;
			kgen_cnt_q <= kcnt_t'(NumRounds);
		end else if (kgen_cnt_q != '0) begin
			kgen_key_q <= next_round_key(kgen_key_q, kgen_rc_q);
			kgen_rc_q  <= xtime(kgen_rc_q);
			kgen_cnt_q <= kgen_cnt_q - 1'b1;
		end
	end

	assign key_ready    = (kgen_cnt_q == '0);
	assign advance      = !out_valid_q || out_ch.ready;
	assign in_ch.ready  = advance && key_ready;
	assign in_blk       = {in_ch.block_high, in_ch.block_low};

	// Entry stage: initial key addition.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl[0] <= '0;
		end else if (advance) begin
			ctl[0].valid <= in_ch.valid && key_ready;
			ctl[0].op    <= aes_op_t'(in_ch.opcode);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (in_ch.opcode == OP_DECRYPT) begin
				st[0] <= in_blk ^ kgen_key_q;
				rk[0] <= kgen_key_q;
			end else begin
				st[0] <= in_blk ^ key0;
				rk[0] <= key0;
			end
		end
	end

	for (genvar g = 0; g < NumRounds; g++) begin : g_cell
		byte_t rc_sel;
		// Encrypt cell g builds key g+1; decrypt cell g unwinds key NumRounds-g.
		assign rc_sel = (ctl[g].op == OP_DECRYPT) ? rcon[NumRounds-g] : rcon[g+1];
		aes128_round_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.last     (g == NumRounds-1),
			.rc       (rc_sel),
			.ctl_in   (ctl[g]),
			.state_in (st[g]),
			.key_in   (rk[g]),
			.ctl_s1   (ctl[g+1]),
			.state_s1 (st[g+1]),
			.key_s1   (rk[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= ctl[NumRounds].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) out_q <= st[NumRounds];
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_high = out_q[BlockW-1:HalfW];
	assign out_ch.out_low  = out_q[HalfW-1:0];

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the AES-128 block cipher pipeline.
module tb_top;
	import aes128_pkg::*;

	localparam int Latency = 11;
	localparam int CycleLimit = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #2 clk = ~clk;

	aes128_in_if  in_ch ();
	aes128_out_if out_ch ();
	aes128_cfg_if cfg ();

	aes128_block_cipher dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
	);

	typedef struct packed {
		logic [HalfW-1:0] hi;
		logic [HalfW-1:0] lo;
	} cipher_out_t;

	logic [HalfW-1:0] key_hi_m, key_lo_m;
	cipher_out_t      pending_blocks [$];
	int               errors = 0;
	int               cycles = 0;
	bit               sink_stall_on = 1'b1;

	function automatic byte_t gf_dbl(byte_t v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
	endfunction

	function automatic byte_t gf_mul(byte_t x, byte_t y);
		byte_t acc;
		acc = 8'h00;
		for (int n = 0; n < 8; n++) begin
			if (y[0]) acc ^= x;
			x = gf_dbl(x);
			y = y >> 1;
		end
		return acc;
	endfunction

	// Full AES-128 on one block with the current key model.
	function automatic cipher_out_t aes_predict(aes_op_t op, logic [HalfW-1:0] bh,
			logic [HalfW-1:0] bl);
		byte_t rk [11][16];
		byte_t s [16];
		byte_t t [16];
		byte_t w [4];
		byte_t cf [4];
		byte_t rc, acc;
		cipher_out_t res;
		int src;
		for (int n = 0; n < 8; n++) begin
			rk[0][n]   = key_hi_m[63-8*n -: 8];
			rk[0][n+8] = key_lo_m[63-8*n -: 8];
			s[n]       = bh[63-8*n -: 8];
			s[n+8]     = bl[63-8*n -: 8];
		end
		rc = 8'h01;
		for (int r = 1; r <= 10; r++) begin
			w[0] = SBOX_FWD[rk[r-1][13]] ^ rc;
			w[1] = SBOX_FWD[rk[r-1][14]];
			w[2] = SBOX_FWD[rk[r-1][15]];
			w[3] = SBOX_FWD[rk[r-1][12]];
			for (int n = 0; n < 4; n++) rk[r][n] = rk[r-1][n] ^ w[n];
			for (int n = 4; n < 16; n++) rk[r][n] = rk[r][n-4] ^ rk[r-1][n];
			rc = gf_dbl(rc);
		end
		if (op == OP_DECRYPT) cf = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
		else cf = '{8'h02, 8'h03, 8'h01, 8'h01};
		for (int n = 0; n < 16; n++) s[n] ^= rk[op == OP_DECRYPT ? 10 : 0][n];
		for (int step = 1; step <= 10; step++) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++) begin
					src = (op == OP_DECRYPT) ? ((c + 4 - r) & 3) : ((c + r) & 3);
					t[c*4+r] = (op == OP_DECRYPT) ? SBOX_INV[s[src*4+r]] : SBOX_FWD[s[src*4+r]];
				end
			s = t;
			if (op == OP_DECRYPT) for (int n = 0; n < 16; n++) s[n] ^= rk[10-step][n];
			if (step < 10) begin
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++) begin
						acc = 8'h00;
						for (int k = 0; k < 4; k++) acc ^= gf_mul(cf[(k - r + 4) & 3], s[c*4+k]);
						t[c*4+r] = acc;
					end
				s = t;
			end
			if (op == OP_ENCRYPT) for (int n = 0; n < 16; n++) s[n] ^= rk[step][n];
		end
		for (int n = 0; n < 8; n++) begin
			res.hi[63-8*n -: 8] = s[n];
			res.lo[63-8*n -: 8] = s[n+8];
		end
		return res;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	// Valid stays high after acceptance; drop it only before a gap or a drain.
	task automatic send_block(aes_op_t op, logic [HalfW-1:0] bh, logic [HalfW-1:0] bl,
			bit use_gaps);
		int g;
		g = use_gaps ? gap_len() : 0;
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= op;
		in_ch.block_high <= bh;
		in_ch.block_low <= bl;
		pending_blocks = {pending_blocks, aes_predict(op, bh, bl)};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_blocks.size() != 0) @(posedge clk);
		repeat (Latency + 4) @(posedge clk);
	endtask

	task automatic write_key(aes_reg_t idx, logic [HalfW-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		if (idx == REG_KEY_HIGH) key_hi_m = value;
		else key_lo_m = value;
	endtask

	task automatic set_key(logic [HalfW-1:0] kh, logic [HalfW-1:0] kl);
		drain();
		write_key(REG_KEY_HIGH, kh);
		write_key(REG_KEY_LOW, kl);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [HalfW-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic test_known_vector();
		// FIPS-197 appendix C.1 vector, both directions
		set_key(64'h0001020304050607, 64'h08090A0B0C0D0E0F);
		send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899AABBCCDDEEFF, 1'b0);
		send_block(OP_DECRYPT, 64'h69C4E0D86A7B0430, 64'hD8CDB78070B4C55A, 1'b0);
	endtask

	task automatic test_extremes();
		set_key('0, '0);
		send_block(OP_ENCRYPT, '0, '0, 1'b0);
		send_block(OP_DECRYPT, '0, '0, 1'b0);
		send_block(OP_ENCRYPT, '1, '1, 1'b0);
		send_block(OP_DECRYPT, '1, '1, 1'b0);
		set_key('1, '1);
		send_block(OP_ENCRYPT, '0, '1, 1'b0);
		send_block(OP_DECRYPT, '1, '0, 1'b0);
		send_block(OP_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001, 1'b0);
		send_block(OP_DECRYPT, 64'h0000000000000001, 64'h8000000000000000, 1'b0);
		// byte placement: distinct bytes in every column and row
		set_key(64'h0F0E0D0C0B0A0908, 64'h0706050403020100);
		send_block(OP_ENCRYPT, 64'h0102030405060708, 64'h090A0B0C0D0E0F10, 1'b0);
		send_block(OP_DECRYPT, 64'h0102030405060708, 64'h090A0B0C0D0E0F10, 1'b0);
	endtask

	task automatic test_random_stream();
		logic [HalfW-1:0] bh, bl;
		for (int ph = 0; ph < 6; ph++) begin
			set_key(rand64(), rand64());
			sink_stall_on = (ph != 2);
			for (int i = 0; i < 140; i++) begin
				bh = rand64();
				bl = rand64();
				send_block(aes_op_t'($urandom_range(0, 1)), bh, bl, ph != 3);
			end
		end
	endtask

	// Receiver: optional random stall; compare each result to the oldest prediction.
	always @(posedge clk) begin
		cipher_out_t exp_blk;
		cycles <= cycles + 1;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_blocks.size() == 0) begin
				$error("unexpected result out_high=%h out_low=%h", out_ch.out_high, out_ch.out_low);
				errors = errors + 1;
			end else begin
				exp_blk = pending_blocks.pop_front();
				if (out_ch.out_high !== exp_blk.hi) begin
					$error("out_high expected %h actual %h", exp_blk.hi, out_ch.out_high);
					errors = errors + 1;
				end
				if (out_ch.out_low !== exp_blk.lo) begin
					$error("out_low expected %h actual %h", exp_blk.lo, out_ch.out_low);
					errors = errors + 1;
				end
			end
		end
		if (!arst_n) out_ch.ready <= 1'b0;
		else if (!sink_stall_on) out_ch.ready <= 1'b1;
		else if ($urandom_range(0, 49) == 0) out_ch.ready <= 1'b0;
		else if ($urandom_range(0, 3) == 0) out_ch.ready <= ~out_ch.ready;
		else out_ch.ready <= 1'b1;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.opcode = 1'b0;
		in_ch.block_high = '0;
		in_ch.block_low = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		key_hi_m = '0;
		key_lo_m = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_known_vector();
		test_extremes();
		test_random_stream();
		drain();
		if (errors == 0 && pending_blocks.size() == 0) $display("tb_top OK");
		else $display("tb_top NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

endmodule

@@ files.f @@
hw/rtl/aes128_pkg.sv
hw/rtl/aes128_if.sv
hw/rtl/aes128_round_cell.sv
hw/rtl/aes128_block_cipher.sv
test/tb_top.sv
